// ----- src/mfek_pkg.sv -----
// Shared types and codes for the max-flow block.
package mfek_pkg;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_SOLVE = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_SAT   = 2'd2
  } status_e;

  localparam int unsigned FlowWidth = 21;
  localparam logic [FlowWidth-1:0] FLOW_MAX = 21'h1FFFFF;
  localparam int unsigned CountWidth = 7;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_ACCEPT,
    DP_CLR,
    DP_ADD0,
    DP_ADD1,
    DP_ADD2,
    DP_ADD3,
    DP_ADD4,
    DP_INIT,
    DP_POP,
    DP_PCAP,
    DP_BCAP,
    DP_SCAN,
    DP_PRD,
    DP_APAR,
    DP_AR2,
    DP_AW1,
    DP_AW2,
    DP_OUT
  } dp_act_e;

  typedef struct packed {
    dp_act_e act;
  } mfek_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic add_bad;
    logic add_sat;
    logic self_loop;
    logic q_empty;
    logic p_is_sink;
    logic scan_done;
    logic aug_stop;
  } mfek_stat_t;

endpackage

// ----- src/mfek_ctrl.sv -----
// Sequencer for edge insertion, matrix clearing and the augmenting-path search.
module mfek_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         op_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  mfek_pkg::mfek_stat_t stat_i,
  output mfek_pkg::mfek_cmd_t  cmd_o
);
  import mfek_pkg::*;

  typedef enum logic [18:0] {
    ST_RST_CLR = 19'h00001,
    ST_IDLE    = 19'h00002,
    ST_CLR     = 19'h00004,
    ST_ADD0    = 19'h00008,
    ST_ADD1    = 19'h00010,
    ST_ADD2    = 19'h00020,
    ST_ADD3    = 19'h00040,
    ST_ADD4    = 19'h00080,
    ST_INIT    = 19'h00100,
    ST_POP     = 19'h00200,
    ST_POPW    = 19'h00400,
    ST_BRD     = 19'h00800,
    ST_SCAN    = 19'h01000,
    ST_ACHK    = 19'h02000,
    ST_APAR    = 19'h04000,
    ST_AR2     = 19'h08000,
    ST_AW1     = 19'h10000,
    ST_AW2     = 19'h20000,
    ST_DONE    = 19'h40000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   out_free;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && (state_q == ST_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cmd_o.act   = DP_NOP;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_RST_CLR: begin
        cmd_o.act = DP_CLR;
        if (stat_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          cmd_o.act = DP_ACCEPT;
          case (op_i)
            OP_ADD:   state_d = ST_ADD0;
            OP_SOLVE: state_d = ST_INIT;
            OP_CLEAR: state_d = ST_CLR;
            default:  state_d = ST_DONE;
          endcase
        end
      end
      ST_CLR: begin
        cmd_o.act = DP_CLR;
        if (stat_i.clr_last) state_d = ST_DONE;
      end
      ST_ADD0: begin
        cmd_o.act = DP_ADD0;
        state_d   = stat_i.add_bad ? ST_DONE : ST_ADD1;
      end
      ST_ADD1: begin
        cmd_o.act = DP_ADD1;
        state_d   = ST_ADD2;
      end
      ST_ADD2: begin
        cmd_o.act = DP_ADD2;
        state_d   = ST_ADD3;
      end
      ST_ADD3: begin
        cmd_o.act = DP_ADD3;
        state_d   = (stat_i.add_sat || stat_i.self_loop) ? ST_DONE : ST_ADD4;
      end
      ST_ADD4: begin
        cmd_o.act = DP_ADD4;
        state_d   = ST_DONE;
      end
      ST_INIT: begin
        cmd_o.act = DP_INIT;
        state_d   = ST_POP;
      end
      ST_POP: begin
        if (stat_i.q_empty) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.act = DP_POP;
          state_d   = ST_POPW;
        end
      end
      ST_POPW: begin
        cmd_o.act = DP_PCAP;
        state_d   = ST_BRD;
      end
      ST_BRD: begin
        cmd_o.act = DP_BCAP;
        state_d   = stat_i.p_is_sink ? ST_ACHK : ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.act = DP_SCAN;
        if (stat_i.scan_done) state_d = ST_POP;
      end
      ST_ACHK: begin
        if (stat_i.aug_stop) begin
          state_d = ST_INIT;
        end else begin
          cmd_o.act = DP_PRD;
          state_d   = ST_APAR;
        end
      end
      ST_APAR: begin
        cmd_o.act = DP_APAR;
        state_d   = ST_AR2;
      end
      ST_AR2: begin
        cmd_o.act = DP_AR2;
        state_d   = ST_AW1;
      end
      ST_AW1: begin
        cmd_o.act = DP_AW1;
        state_d   = ST_AW2;
      end
      ST_AW2: begin
        cmd_o.act = DP_AW2;
        state_d   = ST_ACHK;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.act   = DP_OUT;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RST_CLR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- src/mfek_dp.sv -----
// Residual matrix, search memories and arithmetic for the max-flow block.
module mfek_dp #(
  parameter int unsigned MAX_NODES = 64,
  parameter int unsigned CAP_WIDTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mfek_pkg::mfek_cmd_t                 cmd_i,
  output mfek_pkg::mfek_stat_t                stat_o,
  input  logic [1:0]                          op_i,
  input  logic [5:0]                          node_a_i,
  input  logic [5:0]                          node_b_i,
  input  logic                                cfg_we_i,
  input  logic [mfek_pkg::CountWidth-1:0]     cfg_data_i,
  output logic [mfek_pkg::FlowWidth-1:0]      maxflow_o,
  output logic [1:0]                          status_o
);
  import mfek_pkg::*;

  localparam int unsigned NW    = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned CW    = $clog2(MAX_NODES + 1);
  localparam int unsigned Depth = MAX_NODES * MAX_NODES;
  localparam int unsigned MW    = $clog2(Depth);
  localparam logic [MW-1:0] LastAddr = MW'(Depth - 1);
  localparam logic [CAP_WIDTH:0] CapLimit = {2'b00, {(CAP_WIDTH-1){1'b1}}};
  localparam logic [CAP_WIDTH-1:0] CapOnes = {CAP_WIDTH{1'b1}};

  function automatic logic [MW-1:0] cell_addr(input logic [NW-1:0] r, input logic [NW-1:0] c);
    return MW'(MW'(r) * MW'(MAX_NODES)) + MW'(c);
  endfunction

  logic [CAP_WIDTH-1:0] mat_mem [Depth];
  logic [CAP_WIDTH-1:0] bn_mem  [MAX_NODES];
  logic [NW-1:0]        par_mem [MAX_NODES];
  logic [NW-1:0]        que_mem [MAX_NODES];

  logic                 m_we, m_re;
  logic [MW-1:0]        m_waddr, m_raddr;
  logic [CAP_WIDTH-1:0] m_wdata, m_rdata_q;
  logic                 bn_we, bn_re;
  logic [NW-1:0]        bn_waddr, bn_raddr;
  logic [CAP_WIDTH-1:0] bn_wdata, bn_rdata_q;
  logic                 par_we, par_re;
  logic [NW-1:0]        par_rdata_q;
  logic                 que_we, que_re;
  logic [NW-1:0]        que_waddr, que_wdata, que_rdata_q;

  logic [CountWidth-1:0] node_count_q;
  logic [MW-1:0]         clr_q;
  logic [MAX_NODES-1:0]  visited_q;
  logic                  pend_q;
  logic [1:0]            op_q;
  logic [5:0]            a_raw_q, b_raw_q;
  logic [NW-1:0]         a_q, b_q, p_q, jd_q, cur_q, par_q;
  logic [CW-1:0]         j_q, head_q, tail_q, steps_q;
  logic [CAP_WIDTH-1:0]  bot_q, f_q, c1_q, c2_q;
  logic [FlowWidth-1:0]  total_q, maxflow_q;
  status_e               res_q;
  logic [1:0]            status_q;

  logic [CW-1:0]         n;
  logic [NW-1:0]         sink;
  logic                  hit;
  logic [CAP_WIDTH-1:0]  hit_bn;
  logic [32:0]           flow_sum;
  logic [FlowWidth-1:0]  flow_sat;

  always_comb begin
    if (node_count_q < CountWidth'(2)) begin
      n = CW'(2);
    end else if (32'(node_count_q) > MAX_NODES) begin
      n = CW'(MAX_NODES);
    end else begin
      n = CW'(node_count_q);
    end
  end

  assign sink     = NW'(n - CW'(1));
  assign hit      = pend_q && !visited_q[jd_q] && (m_rdata_q != '0);
  assign hit_bn   = (m_rdata_q < bot_q) ? m_rdata_q : bot_q;
  assign flow_sum = 33'(total_q) + 33'(bn_rdata_q);
  assign flow_sat = (flow_sum > 33'(FLOW_MAX)) ? FLOW_MAX : flow_sum[FlowWidth-1:0];

  assign stat_o.clr_last  = (clr_q == LastAddr);
  assign stat_o.add_bad   = (32'(a_raw_q) >= 32'(n)) || (32'(b_raw_q) >= 32'(n));
  assign stat_o.self_loop = (a_q == b_q);
  assign stat_o.add_sat   = (a_q == b_q) ? ((CAP_WIDTH+1)'(c1_q) + (CAP_WIDTH+1)'(2) > CapLimit)
                          : (((CAP_WIDTH+1)'(c1_q) + (CAP_WIDTH+1)'(1) > CapLimit) ||
                             ((CAP_WIDTH+1)'(c2_q) + (CAP_WIDTH+1)'(1) > CapLimit));
  assign stat_o.q_empty   = (head_q == tail_q);
  assign stat_o.p_is_sink = (p_q == sink);
  assign stat_o.scan_done = (j_q >= n);
  assign stat_o.aug_stop  = !visited_q[cur_q] || (steps_q >= n);

  always_comb begin
    m_we      = 1'b0;
    m_waddr   = '0;
    m_wdata   = '0;
    m_re      = 1'b0;
    m_raddr   = '0;
    bn_we     = 1'b0;
    bn_waddr  = '0;
    bn_wdata  = '0;
    bn_re     = 1'b0;
    bn_raddr  = '0;
    par_we    = hit && (cmd_i.act == DP_SCAN);
    par_re    = 1'b0;
    que_we    = 1'b0;
    que_waddr = '0;
    que_wdata = '0;
    que_re    = 1'b0;
    case (cmd_i.act)
      DP_CLR: begin
        m_we    = 1'b1;
        m_waddr = clr_q;
      end
      DP_ADD0: begin
        m_re    = 1'b1;
        m_raddr = cell_addr(a_q, b_q);
      end
      DP_ADD1: begin
        m_re    = 1'b1;
        m_raddr = cell_addr(b_q, a_q);
      end
      DP_ADD3: begin
        m_we    = !stat_o.add_sat;
        m_waddr = cell_addr(a_q, b_q);
        m_wdata = (a_q == b_q) ? CAP_WIDTH'(c1_q + CAP_WIDTH'(2)) : CAP_WIDTH'(c1_q + CAP_WIDTH'(1));
      end
      DP_ADD4: begin
        m_we    = 1'b1;
        m_waddr = cell_addr(b_q, a_q);
        m_wdata = CAP_WIDTH'(c2_q + CAP_WIDTH'(1));
      end
      DP_INIT: begin
        bn_we     = 1'b1;
        bn_wdata  = CapOnes;
        que_we    = 1'b1;
      end
      DP_POP: que_re = 1'b1;
      DP_PCAP: begin
        bn_re    = 1'b1;
        bn_raddr = que_rdata_q;
      end
      DP_SCAN: begin
        if (j_q < n) begin
          m_re    = 1'b1;
          m_raddr = cell_addr(p_q, j_q[NW-1:0]);
        end
        if (hit) begin
          bn_we     = 1'b1;
          bn_waddr  = jd_q;
          bn_wdata  = hit_bn;
          que_we    = 1'b1;
          que_waddr = tail_q[NW-1:0];
          que_wdata = jd_q;
        end
      end
      DP_PRD: par_re = 1'b1;
      DP_APAR: begin
        m_re    = 1'b1;
        m_raddr = cell_addr(cur_q, par_rdata_q);
      end
      DP_AR2: begin
        m_re    = 1'b1;
        m_raddr = cell_addr(par_q, cur_q);
      end
      DP_AW1: begin
        m_we    = 1'b1;
        m_waddr = cell_addr(cur_q, par_q);
        m_wdata = CAP_WIDTH'(c1_q + f_q);
      end
      DP_AW2: begin
        m_we    = 1'b1;
        m_waddr = cell_addr(par_q, cur_q);
        m_wdata = CAP_WIDTH'(c2_q - f_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (m_we) mat_mem[m_waddr] <= m_wdata;
    if (m_re) m_rdata_q <= mat_mem[m_raddr];
    if (bn_we) bn_mem[bn_waddr] <= bn_wdata;
    if (bn_re) bn_rdata_q <= bn_mem[bn_raddr];
    if (par_we) par_mem[jd_q] <= p_q;
    if (par_re) par_rdata_q <= par_mem[cur_q];
    if (que_we) que_mem[que_waddr] <= que_wdata;
    if (que_re) que_rdata_q <= que_mem[head_q[NW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= CountWidth'(64);
      clr_q        <= '0;
      visited_q    <= '0;
      pend_q       <= 1'b0;
    end else begin
      if (cfg_we_i) node_count_q <= cfg_data_i;
      if (cmd_i.act == DP_CLR) clr_q <= stat_o.clr_last ? '0 : MW'(clr_q + MW'(1));
      if (cmd_i.act == DP_INIT) visited_q <= '0;
      else if (cmd_i.act == DP_SCAN && hit) visited_q[jd_q] <= 1'b1;
      if (cmd_i.act == DP_SCAN) pend_q <= (j_q < n);
      else pend_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.act)
      DP_ACCEPT: begin
        op_q    <= op_i;
        a_raw_q <= node_a_i;
        b_raw_q <= node_b_i;
        a_q     <= NW'(node_a_i);
        b_q     <= NW'(node_b_i);
        total_q <= '0;
        res_q   <= STAT_OK;
      end
      DP_ADD0: if (stat_o.add_bad) res_q <= STAT_RANGE;
      DP_ADD1: c1_q <= m_rdata_q;
      DP_ADD2: c2_q <= m_rdata_q;
      DP_ADD3: if (stat_o.add_sat) res_q <= STAT_SAT;
      DP_INIT: begin
        head_q <= '0;
        tail_q <= CW'(1);
      end
      DP_POP: head_q <= CW'(head_q + CW'(1));
      DP_PCAP: p_q <= que_rdata_q;
      DP_BCAP: begin
        bot_q <= bn_rdata_q;
        j_q   <= CW'(1);
        if (stat_o.p_is_sink) begin
          f_q     <= bn_rdata_q;
          total_q <= flow_sat;
          cur_q   <= sink;
          steps_q <= '0;
        end
      end
      DP_SCAN: begin
        if (j_q < n) begin
          jd_q <= j_q[NW-1:0];
          j_q  <= CW'(j_q + CW'(1));
        end
        if (hit) tail_q <= CW'(tail_q + CW'(1));
      end
      DP_APAR: par_q <= par_rdata_q;
      DP_AR2: c1_q <= m_rdata_q;
      DP_AW1: c2_q <= m_rdata_q;
      DP_AW2: begin
        cur_q   <= par_q;
        steps_q <= CW'(steps_q + CW'(1));
      end
      DP_OUT: begin
        maxflow_q <= (op_q == OP_SOLVE) ? total_q : '0;
        status_q  <= res_q;
      end
      default: ;
    endcase
  end

  assign maxflow_o = maxflow_q;
  assign status_o  = status_q;

endmodule

// ----- src/max_flow_edmonds_karp.sv -----
// Max-flow top level for the add_edge, clear and solve operations.
// Solve repeats a breadth-first search that scans each node taken from the queue,
// then walks each augmenting path back edge by edge; the matrix has one read port.
// One item is in work at a time; the result register frees the input side.
// Reset clears control state and then sweeps every matrix cell to zero with
// in_stall_o high; configuration writes are taken throughout.
module max_flow_edmonds_karp #(
  parameter int unsigned MAX_NODES = 64,
  parameter int unsigned CAP_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [5:0]  node_a_i,
  input  logic [5:0]  node_b_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [20:0] maxflow_o,
  output logic [1:0]  status_o,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_data_i
);
  import mfek_pkg::*;

  mfek_cmd_t  cmd;
  mfek_stat_t stat;

  mfek_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  mfek_dp #(
    .MAX_NODES (MAX_NODES),
    .CAP_WIDTH (CAP_WIDTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .op_i       (op_i),
    .node_a_i   (node_a_i),
    .node_b_i   (node_b_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .maxflow_o  (maxflow_o),
    .status_o   (status_o)
  );

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while an item is in work");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != 2'd3)
    else $error("undefined status code");

  a_error_no_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != STAT_OK) |-> maxflow_o == '0)
    else $error("flow reported with an error status");

endmodule
